// ===== rtl/cbp_pkg.sv =====
package cbp_pkg;

  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int SYM_W        = 8;
  localparam int BYTE_W       = 8;
  localparam int PEND_W       = BYTE_W - 1;
  localparam int CNT_W        = 3;
  localparam int MAX_CODE_LEN = 32;
  localparam int CODE_LIMIT_I = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int ACC_W        = PEND_W + CODE_LIMIT_I;
  localparam int NBYTES       = 4;
  localparam int IDX_W        = 2;
  localparam int TOTAL_W      = LEN_W;
  localparam int DEPTH        = 1 << SYM_W;

  localparam logic [LEN_W-1:0]   CODE_LIMIT = LEN_W'(CODE_LIMIT_I);
  localparam logic [TOTAL_W-1:0] ACC_WIDTH  = TOTAL_W'(ACC_W);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0]                  cnt;
    logic [NBYTES-1:0][BYTE_W-1:0]     bytes;
    logic                              byte_valid;
    logic [CNT_W-1:0]                  pad_bits;
    logic                              stream_end;
  } group_t;

endpackage

// ===== rtl/cbp_table.sv =====
module cbp_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [cbp_pkg::SYM_W-1:0] wr_addr,
  input  logic [cbp_pkg::CODE_W-1:0] wr_code,
  input  logic [cbp_pkg::LEN_W-1:0] wr_len,
  input  logic                      rd_en,
  input  logic [cbp_pkg::SYM_W-1:0] rd_addr,
  output logic [cbp_pkg::CODE_W-1:0] rd_code,
  output logic [cbp_pkg::LEN_W-1:0] rd_len
);
  import cbp_pkg::*;

  logic [CODE_W+LEN_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]        vld;
  logic [CODE_W+LEN_W-1:0] rd_data;
  logic                    rd_vld;
  logic [LEN_W-1:0]        len_sat;

  assign len_sat = (wr_len > CODE_LIMIT) ? CODE_LIMIT : wr_len;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_code, len_sat};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_code = rd_data[CODE_W+LEN_W-1:LEN_W];
  assign rd_len  = rd_vld ? rd_data[LEN_W-1:0] : '0;

endmodule

// ===== rtl/cbp_packer.sv =====
module cbp_packer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s1_valid,
  input  logic                       s1_end,
  input  logic [cbp_pkg::CODE_W-1:0] code,
  input  logic [cbp_pkg::LEN_W-1:0]  len,
  input  logic                       em_ready,
  output logic                       adv,
  output logic                       push,
  output cbp_pkg::group_t            grp
);
  import cbp_pkg::*;

  logic [PEND_W-1:0]  pending_bits;
  logic [CNT_W-1:0]   pending_count;
  logic [PEND_W-1:0]  pending_bits_next;
  logic [CNT_W-1:0]   pending_count_next;
  logic [CODE_W:0]    code_mask;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   aligned;
  logic [TOTAL_W-1:0] total;
  logic [CNT_W-1:0]   pad;

  always_comb begin
    code_mask = ~({(CODE_W+1){1'b1}} << len);
    acc       = (ACC_W'(pending_bits) << len) | ACC_W'(code & code_mask[CODE_W-1:0]);
    total     = TOTAL_W'(pending_count) + len;
    aligned   = acc << (ACC_WIDTH - total);
    pad       = CNT_W'(4'd8 - {1'b0, pending_count});

    grp = '0;
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    if (s1_end) begin
      grp.cnt        = CNT_W'(1);
      grp.stream_end = 1'b1;
      if (pending_count != '0) begin
        grp.byte_valid = 1'b1;
        grp.pad_bits   = pad;
        grp.bytes[0]   = BYTE_W'({1'b0, pending_bits} << pad);
      end
      pending_bits_next  = '0;
      pending_count_next = '0;
    end else begin
      grp.cnt        = total[TOTAL_W-1:CNT_W];
      grp.byte_valid = 1'b1;
      for (int k = 0; k < NBYTES; k++) begin
        grp.bytes[k] = aligned[ACC_W-1-BYTE_W*k -: BYTE_W];
      end
      pending_count_next = total[CNT_W-1:0];
      pending_bits_next  = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << total[CNT_W-1:0]);
    end

    adv  = s1_valid && ((grp.cnt == '0) || em_ready);
    push = adv && (grp.cnt != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else if (adv) begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

endmodule

// ===== rtl/cbp_emitter.sv =====
module cbp_emitter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  cbp_pkg::group_t            grp_in,
  output logic                       ready,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cbp_pkg::BYTE_W-1:0] out_byte,
  output logic                       byte_valid,
  output logic [cbp_pkg::CNT_W-1:0]  pad_bits,
  output logic                       stream_end,
  output logic                       last
);
  import cbp_pkg::*;

  group_t           grp;
  logic             busy;
  logic [IDX_W-1:0] idx;
  logic             take;

  assign out_valid  = busy;
  assign take       = busy && !out_stall;
  assign last       = idx == IDX_W'(grp.cnt - CNT_W'(1));
  assign ready      = !busy || (take && last);
  assign out_byte   = grp.bytes[idx];
  assign byte_valid = grp.byte_valid;
  assign pad_bits   = grp.pad_bits;
  assign stream_end = grp.stream_end;

  always_ff @(posedge clk) begin
    if (push) begin
      grp <= grp_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (push) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

endmodule

// ===== rtl/code_table_bit_packer.sv =====
// Huffman bit packer. Load requests write a 256-entry code table; the table
// comes out of reset with every length at 0 through per-entry valid flags,
// so no clearing pass is needed. An encode request reads the table in the
// cycle after acceptance, then packs the code with the carried-over bits
// and hands zero to four bytes to the output stage, which sends one result
// per cycle while out_stall is low, most significant bit first. An end
// request sends exactly one result with the pad count. Requests enter on
// back-to-back cycles while in_stall is low; the sustained rate is set by
// requests or result bytes, whichever is slower, via the single output port.
module code_table_bit_packer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 op,
  input  logic [cbp_pkg::SYM_W-1:0]  symbol,
  input  logic [cbp_pkg::CODE_W-1:0] code_bits,
  input  logic [cbp_pkg::LEN_W-1:0]  code_length,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cbp_pkg::BYTE_W-1:0] out_byte,
  output logic                       byte_valid,
  output logic [cbp_pkg::CNT_W-1:0]  pad_bits,
  output logic                       stream_end,
  output logic                       last
);
  import cbp_pkg::*;

  logic              accept;
  logic              s1_valid;
  logic              s1_end;
  logic              adv;
  logic              push;
  logic              em_ready;
  logic [CODE_W-1:0] rd_code;
  logic [LEN_W-1:0]  rd_len;
  group_t            grp;

  assign in_stall = s1_valid && !adv;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_end   <= 1'b0;
    end else if (accept) begin
      s1_valid <= (op == OP_ENCODE) || (op == OP_END);
      s1_end   <= op == OP_END;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  cbp_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && (op == OP_LOAD)),
    .wr_addr (symbol),
    .wr_code (code_bits),
    .wr_len  (code_length),
    .rd_en   (accept && (op == OP_ENCODE)),
    .rd_addr (symbol),
    .rd_code (rd_code),
    .rd_len  (rd_len)
  );

  cbp_packer u_packer (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_end   (s1_end),
    .code     (rd_code),
    .len      (rd_len),
    .em_ready (em_ready),
    .adv      (adv),
    .push     (push),
    .grp      (grp)
  );

  cbp_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .grp_in     (grp),
    .ready      (em_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .pad_bits   (pad_bits),
    .stream_end (stream_end),
    .last       (last)
  );

endmodule
